>>> src/sorted_name_table_lookup_top_assert.svh
`ifndef SORTED_NAME_TABLE_LOOKUP_TOP_ASSERT_SVH
`define SORTED_NAME_TABLE_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SNLT_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snlt check failed");

// next-cycle implication
`define SNLT_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snlt check failed");

`endif

>>> src/snlt_pkg.sv
package snlt_pkg;

  localparam int ENTRIES_DEF    = 512;
  localparam int NAME_BYTES_DEF = 12;
  localparam logic [7:0] DEFAULT_TYPE_RST = 8'd67;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_SORT   = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // queued word header, key travels beside it
  typedef struct packed {
    logic       valid;
    func_t      func;
    logic [7:0] type_code;
  } qhdr_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

>>> src/snlt_ram.sv
module snlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> src/snlt_front.sv
module snlt_front #(
  parameter int NAME_BYTES = snlt_pkg::NAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [63:0]             in_name_lo,
  input  logic [31:0]             in_name_hi,
  input  logic [7:0]              in_type_code,
  output snlt_pkg::qhdr_t         q,
  output logic [8*NAME_BYTES-1:0] q_key,
  input  logic                    q_pop
);

  localparam int KW = 8 * NAME_BYTES;

  logic [KW-1:0]   key;
  logic [KW-1:0]   fifo_key_r [2];
  snlt_pkg::func_t fifo_fn_r  [2];
  logic [7:0]      fifo_ty_r  [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push;

  // key: byte 0 at the top, folded, zero from the first zero byte on
  always_comb begin
    logic [95:0] raw;
    logic [7:0]  c;
    logic        ended;
    raw   = {in_name_hi, in_name_lo};
    ended = 1'b0;
    key   = '0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      c = raw[8*k +: 8];
      if (c == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        key[KW-1-8*k -: 8] = snlt_pkg::fold_byte(c);
      end
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_key_r[wp_r] <= key;
      fifo_fn_r[wp_r]  <= snlt_pkg::func_t'(in_func);
      fifo_ty_r[wp_r]  <= in_type_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q.valid     = (cnt_r != 2'd0);
  assign q.func      = fifo_fn_r[rp_r];
  assign q.type_code = fifo_ty_r[rp_r];
  assign q_key       = fifo_key_r[rp_r];

endmodule

>>> src/snlt_back.sv
module snlt_back #(
  parameter int ENTRIES    = snlt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = snlt_pkg::NAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  snlt_pkg::qhdr_t         q,
  input  logic [8*NAME_BYTES-1:0] q_key,
  output logic                    q_pop,
  input  logic [7:0]              default_type,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_result_type,
  output logic [1:0]              out_status,
  output logic [9:0]              out_entry_total
);

  localparam int KW = 8 * NAME_BYTES;
  localparam int DW = KW + 8;
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LK   = 6'b000010,
    S_SI   = 6'b000100,
    S_SJ   = 6'b001000,
    S_WI   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [DW-1:0] hold_r, hold_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, mid_r, mid_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [7:0]    res_type_r, res_type_nxt;
  logic [1:0]    res_stat_r, res_stat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_type_r, out_type_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [9:0]    out_total_r, out_total_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [KW-1:0] rd_key;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] nxt_i, nxt_j;

  snlt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata_r(rdata)
  );

  assign rd_key = rdata[DW-1:8];
  assign nxt_i  = CW'(i_r) + CW'(1);
  assign nxt_j  = CW'(j_r) + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    hold_nxt      = hold_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_type_nxt  = res_type_r;
    res_stat_nxt  = res_stat_r;
    out_type_nxt  = out_type_r;
    out_stat_nxt  = out_stat_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q.valid) begin
          q_pop        = 1'b1;
          res_type_nxt = 8'd0;
          res_stat_nxt = snlt_pkg::STAT_OK;
          state_nxt    = S_DONE;
          unique case (q.func)
            snlt_pkg::FN_APPEND: begin
              if (count_r >= CW'(ENTRIES)) begin
                res_stat_nxt = snlt_pkg::STAT_FULL;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = {q_key, q.type_code};
                count_nxt = count_r + CW'(1);
              end
            end
            snlt_pkg::FN_CLEAR: begin
              count_nxt = '0;
            end
            snlt_pkg::FN_SORT: begin
              if (count_r != '0) begin
                i_nxt     = '0;
                state_nxt = S_SI;
              end
            end
            snlt_pkg::FN_LOOKUP: begin
              key_nxt = q_key;
              lo_nxt  = '0;
              hi_nxt  = count_r;
              if (count_r == '0) begin
                res_type_nxt = default_type;
                res_stat_nxt = snlt_pkg::STAT_MISS;
              end else begin
                state_nxt = S_LK;
              end
            end
            default: ;
          endcase
        end
      end
      S_LK: begin
        // hi holds right + 1, so the window is [lo, hi)
        if (rd_key == key_r) begin
          res_type_nxt = rdata[7:0];
          res_stat_nxt = snlt_pkg::STAT_OK;
          state_nxt    = S_DONE;
        end else begin
          if (key_r > rd_key) begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end else begin
            hi_nxt = CW'(mid_r);
          end
          if (lo_nxt >= hi_nxt) begin
            res_type_nxt = default_type;
            res_stat_nxt = snlt_pkg::STAT_MISS;
            state_nxt    = S_DONE;
          end
        end
      end
      S_SI: begin
        hold_nxt = rdata;
        if (nxt_i >= count_r) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = nxt_i[AW-1:0];
          state_nxt = S_SJ;
        end
      end
      S_SJ: begin
        // hold_r mirrors entry i; swap writes j and keeps the smaller name
        if (hold_r[DW-1:8] > rd_key) begin
          we       = 1'b1;
          waddr    = j_r;
          wdata    = hold_r;
          hold_nxt = rdata;
        end
        if (nxt_j < count_r) begin
          j_nxt = nxt_j[AW-1:0];
        end else begin
          state_nxt = S_WI;
        end
      end
      S_WI: begin
        we        = 1'b1;
        waddr     = i_r;
        wdata     = hold_r;
        i_nxt     = nxt_i[AW-1:0];
        state_nxt = S_SI;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = res_type_r;
          out_stat_nxt  = res_stat_r;
          out_total_nxt = 10'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // read address for the next cycle
    mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt} - (CW+1)'(1);
    if (state_nxt == S_LK) begin
      mid_nxt = mid_sum[AW:1];
      raddr   = mid_nxt;
    end else if (state_nxt == S_SI) begin
      raddr = i_nxt;
    end else if (state_nxt == S_SJ) begin
      raddr = j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    hold_r      <= hold_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    mid_r       <= mid_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    res_type_r  <= res_type_nxt;
    res_stat_r  <= res_stat_nxt;
    out_type_r  <= out_type_nxt;
    out_stat_r  <= out_stat_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_type = out_type_r;
  assign out_status      = out_stat_r;
  assign out_entry_total = out_total_r;

endmodule

>>> src/sorted_name_table_lookup_top.sv
// Accept to out_valid: a word is taken in IDLE, its result goes from DONE to the registered
// out_valid; a lookup of a non-empty table probes in LK first, k probes of the binary search
// (at most ceil(log2(n+1))), one RAM read each; a sort of n entries loops SI, SJ, WI, one RAM
// read per compare. One word at a time in the back end; a 2-word queue takes input until full.
// Reset: entry count, queue and result valid cleared, default_type back to 67;
// the name/type RAM is not cleared.
module sorted_name_table_lookup_top #(
  parameter int ENTRIES    = snlt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = snlt_pkg::NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_name_lo,
  input  logic [31:0] in_name_hi,
  input  logic [7:0]  in_type_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_result_type,
  output logic [1:0]  out_status,
  output logic [9:0]  out_entry_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_default_type
);

  snlt_pkg::qhdr_t         q;
  logic [8*NAME_BYTES-1:0] q_key;
  logic                    q_pop;
  logic [7:0]              default_type_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_type_r <= snlt_pkg::DEFAULT_TYPE_RST;
    end else if (cfg_valid) begin
      default_type_r <= cfg_default_type;
    end
  end

  snlt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_name_lo  (in_name_lo),
    .in_name_hi  (in_name_hi),
    .in_type_code(in_type_code),
    .q           (q),
    .q_key       (q_key),
    .q_pop       (q_pop)
  );

  snlt_back #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q              (q),
    .q_key          (q_key),
    .q_pop          (q_pop),
    .default_type   (default_type_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_type(out_result_type),
    .out_status     (out_status),
    .out_entry_total(out_entry_total)
  );

endmodule

>>> src/snlt_check.sv
`include "sorted_name_table_lookup_top_assert.svh"

module snlt_check #(
  parameter int ENTRIES = snlt_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_result_type,
  input logic [1:0] out_status,
  input logic [9:0] out_entry_total
);

  `SNLT_CHK_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_type))
  `SNLT_CHK_IMP(a_stat_code, out_valid, out_status <= snlt_pkg::STAT_FULL)
  `SNLT_CHK_IMP(a_full_total, out_valid && out_status == snlt_pkg::STAT_FULL, out_entry_total == 10'(ENTRIES))
  `SNLT_CHK_IMP(a_full_type, out_valid && out_status == snlt_pkg::STAT_FULL, out_result_type == 8'd0)

endmodule

bind sorted_name_table_lookup_top snlt_check #(.ENTRIES(ENTRIES)) u_chk (.*);
